FILE: src/bttr_pkg.sv
// Shared types, constants and font table of the bitmap text glyph renderer.
package bttr_pkg;

    localparam int CoordBits   = 12;
    localparam int GlyphRows   = 5;
    localparam int FontEntries = 128;
    localparam int MaxCols     = 5;
    localparam int WidthShift  = 28;
    localparam int PixelBits   = GlyphRows * MaxCols;
    localparam int ColorBits   = 24;
    localparam int CodeBits    = 8;
    localparam int RomIdxBits  = $clog2(FontEntries);
    localparam int CfgIdxBits  = 2;

    localparam logic [CoordBits-1:0] CoordMax   = {CoordBits{1'b1}};
    localparam logic [CoordBits-1:0] StartXRst  = CoordBits'(1);
    localparam logic [CoordBits-1:0] RowTopRst  = CoordBits'(1);
    localparam logic [ColorBits-1:0] InkRst     = {ColorBits{1'b1}};

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_START_X   = 2'd0,
        CFG_ROW_TOP   = 2'd1,
        CFG_INK_COLOR = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CoordBits-1:0] start_x;
        logic [CoordBits-1:0] row_top;
        logic [ColorBits-1:0] ink_color;
    } t_cfg;

    typedef struct packed {
        logic [2:0]           width;
        logic [PixelBits-1:0] bits;
    } t_glyph;

    typedef struct packed {
        logic   valid;
        t_glyph glyph;
    } t_glyph_rsp;

    localparam logic [31:0] FontRom [FontEntries] = '{
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'h10000000, 32'h10000017, 32'h30000C03, 32'h50AFABEA,
        32'h509AFEB2, 32'h30004C99, 32'h400A26AA, 32'h10000003,
        32'h2000022E, 32'h200001D1, 32'h30001445, 32'h300011C4,
        32'h10000018, 32'h30001084, 32'h10000010, 32'h30000C98,
        32'h30003A2E, 32'h300043F2, 32'h30004AB9, 32'h30006EB1,
        32'h30007C87, 32'h300026B7, 32'h300076BF, 32'h30007C21,
        32'h30006EBB, 32'h30007EB7, 32'h1000000A, 32'h1000001A,
        32'h30004544, 32'h4005294A, 32'h30001151, 32'h30000AA1,
        32'h506ADE2E, 32'h300078BE, 32'h30002ABF, 32'h3000462E,
        32'h30003A3F, 32'h300046BF, 32'h300004BF, 32'h3000662E,
        32'h30007C9F, 32'h1000001F, 32'h30003E08, 32'h30006C9F,
        32'h3000421F, 32'h51F1105F, 32'h51F4105F, 32'h4007462E,
        32'h300008BF, 32'h400F662E, 32'h300068BF, 32'h300026B2,
        32'h300007E1, 32'h30007E1F, 32'h30003E0F, 32'h50F8320F,
        32'h30006C9B, 32'h30000F83, 32'h30004EB9, 32'h2000023F,
        32'h30006083, 32'h200003F1, 32'h30000822, 32'h30004210,
        32'h20000041, 32'h300078BE, 32'h30002ABF, 32'h3000462E,
        32'h30003A3F, 32'h300046BF, 32'h300004BF, 32'h3000662E,
        32'h30007C9F, 32'h1000001F, 32'h30003E08, 32'h30006C9F,
        32'h3000421F, 32'h51F1105F, 32'h51F4105F, 32'h4007462E,
        32'h300008BF, 32'h400F662E, 32'h300068BF, 32'h300026B2,
        32'h300007E1, 32'h30007E1F, 32'h30003E0F, 32'h50F8320F,
        32'h30006C9B, 32'h30000F83, 32'h30004EB9, 32'h30004764,
        32'h1000001F, 32'h30001371, 32'h50441044, 32'h00000000
    };

endpackage

FILE: src/bttr_if.sv
// Handshake channel interfaces: character input, pixel output, register writes.
interface bttr_char_if;
    import bttr_pkg::*;
    logic                valid;
    logic                ready;
    logic [CodeBits-1:0] char_code;
    logic                restart;
    modport source (output valid, char_code, restart, input ready);
    modport sink   (input valid, char_code, restart, output ready);
endinterface

interface bttr_pix_if;
    import bttr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic                 pixel_on;
    logic [ColorBits-1:0] pixel_color;
    logic [2:0]           glyph_width;
    logic                 last_cell;
    modport source (output valid, pixel_x, pixel_y, pixel_on, pixel_color, glyph_width,
                    last_cell, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_on, pixel_color, glyph_width,
                    last_cell, output ready);
endinterface

interface bttr_cfg_if;
    import bttr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CfgIdxBits-1:0] index;
    logic [ColorBits-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/bttr_font_rom.sv
// Font table lookup with registered output; blanks codes beyond the table.
module bttr_font_rom (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req,
    input  logic [bttr_pkg::CodeBits-1:0] i_code,
    output bttr_pkg::t_glyph_rsp         o_rsp
);
    import bttr_pkg::*;

    logic [31:0] w_entry;
    logic [3:0]  w_nib;
    t_glyph      n_glyph;
    logic        r_valid;
    t_glyph      r_glyph;

    always_comb begin
        if (i_code < CodeBits'(FontEntries)) begin
            w_entry = FontRom[i_code[RomIdxBits-1:0]];
        end else begin
            w_entry = '0;
        end
        w_nib         = w_entry[WidthShift+:4];
        n_glyph.width = (w_nib > 4'(MaxCols)) ? 3'(MaxCols) : w_nib[2:0];
        n_glyph.bits  = w_entry[PixelBits-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_req;
        end
        if (i_req) begin
            r_glyph <= n_glyph;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.glyph = r_glyph;

endmodule

FILE: src/bttr_cell_ser.sv
// Cell serializer: keeps the cursor, shifts out one cell a cycle unless stalled.
module bttr_cell_ser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_restart,
    input  bttr_pkg::t_cfg       i_cfg,
    input  bttr_pkg::t_glyph_rsp i_rsp,
    output logic                 o_idle,
    bttr_pix_if.source           o_pix
);
    import bttr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [CoordBits-1:0] r_cursor;
    logic [PixelBits-1:0] r_bits;
    logic [2:0]           r_width;
    logic [2:0]           r_col;
    logic [2:0]           r_row;
    logic [CoordBits-1:0] r_x;
    logic [CoordBits-1:0] r_y;

    logic                 r_ovld;
    logic [CoordBits-1:0] r_ox;
    logic [CoordBits-1:0] r_oy;
    logic                 r_oon;
    logic [2:0]           r_ow;
    logic                 r_olast;

    logic                 w_slot;
    logic                 w_last;
    logic                 w_row_end;
    logic [CoordBits:0]   w_adv_sum;
    logic [2:0]           w_adv_w;
    logic [CoordBits-1:0] n_adv;
    logic [CoordBits-1:0] n_x_inc;
    logic [CoordBits-1:0] n_y_inc;

    always_comb begin
        w_slot    = !r_ovld || o_pix.ready;
        w_row_end = (r_row == 3'(GlyphRows - 1));
        w_last    = w_row_end && (r_col == r_width - 3'd1);
        w_adv_w   = (r_state == S_FETCH) ? 3'd0 : r_width;
        w_adv_sum = {1'b0, r_cursor} + (CoordBits + 1)'(w_adv_w) + (CoordBits + 1)'(1);
        n_adv     = (w_adv_sum > (CoordBits + 1)'(CoordMax)) ? CoordMax
                                                            : w_adv_sum[CoordBits-1:0];
        n_x_inc   = (r_x == CoordMax) ? CoordMax : r_x + CoordBits'(1);
        n_y_inc   = (r_y == CoordMax) ? CoordMax : r_y + CoordBits'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cursor <= StartXRst;
            r_ovld   <= 1'b0;
        end else begin
            // drop the taken cell unless a new one loads in its place
            if (o_pix.ready && r_state != S_EMIT) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_restart) begin
                            r_cursor <= i_cfg.start_x;
                        end
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (i_rsp.valid) begin
                        r_bits  <= i_rsp.glyph.bits;
                        r_width <= i_rsp.glyph.width;
                        r_col   <= 3'd0;
                        r_row   <= 3'd0;
                        r_x     <= r_cursor;
                        r_y     <= i_cfg.row_top;
                        if (i_rsp.glyph.width == 3'd0) begin
                            // blank glyph: no cells, advance by one column
                            r_cursor <= n_adv;
                            r_state  <= S_IDLE;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_ovld  <= 1'b1;
                        r_ox    <= r_x;
                        r_oy    <= r_y;
                        r_oon   <= r_bits[0];
                        r_ow    <= r_width;
                        r_olast <= w_last;
                        r_bits  <= r_bits >> 1;
                        if (w_row_end) begin
                            r_row <= 3'd0;
                            r_col <= r_col + 3'd1;
                            r_x   <= n_x_inc;
                            r_y   <= i_cfg.row_top;
                        end else begin
                            r_row <= r_row + 3'd1;
                            r_y   <= n_y_inc;
                        end
                        if (w_last) begin
                            r_cursor <= n_adv;
                            r_state  <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle            = (r_state == S_IDLE);
    assign o_pix.valid       = r_ovld;
    assign o_pix.pixel_x     = r_ox;
    assign o_pix.pixel_y     = r_oy;
    assign o_pix.pixel_on    = r_oon;
    assign o_pix.pixel_color = r_oon ? i_cfg.ink_color : '0;
    assign o_pix.glyph_width = r_ow;
    assign o_pix.last_cell   = r_olast;

`ifndef ASSERT_OFF
    a_start_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_state == S_FETCH)
        else $error("accepted character did not enter fetch");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_row < 3'(GlyphRows) && r_col < r_width)
        else $error("cell counters out of range");
    a_emit_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_width != 3'd0 && r_width <= 3'(MaxCols))
        else $error("emitting a glyph with bad width");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && w_slot && w_last |=> r_state == S_IDLE && r_olast)
        else $error("last cell did not close the character");
`endif

endmodule

FILE: src/bitmap_text_glyph_renderer_unit.sv
// Top level of the bitmap text glyph renderer: registers, font lookup, cell serializer.
//
// Each accepted character beat is drawn as a run of glyph cells from a fixed
// 128-entry font, column by column with five rows per column, one cell beat
// per cycle out of a single output register while the output is not stalled.
// For a character of width w (0 to 5) the beat is accepted, the font lookup is
// registered, then the bit shifter sends its 5*w cells; a stalled output
// stretches the cell phase, and no new beat is taken until the character is
// done. Blank glyphs (width zero, and every code of 128 or above) give no
// cell beats and move the cursor one column. The cursor advances by width plus
// one after each character, saturating at the coordinate maximum; a set restart
// flag reloads it from start_x first. Register writes (0 start_x, 1 row_top,
// 2 ink_color, higher indexes dropped) are always accepted and belong to idle periods.
module bitmap_text_glyph_renderer_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bttr_char_if.sink    i_char,
    bttr_cfg_if.sink     i_cfg,
    bttr_pix_if.source   o_pix
);
    import bttr_pkg::*;

    t_cfg       r_cfg;
    t_glyph_rsp w_rsp;
    logic       w_idle;
    logic       w_start;

    // Register writes: always ready, unknown indexes dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_x   <= StartXRst;
            r_cfg.row_top   <= RowTopRst;
            r_cfg.ink_color <= InkRst;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_START_X:   r_cfg.start_x   <= i_cfg.data[CoordBits-1:0];
                CFG_ROW_TOP:   r_cfg.row_top   <= i_cfg.data[CoordBits-1:0];
                CFG_INK_COLOR: r_cfg.ink_color <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Take a new character only between runs
    assign i_char.ready = w_idle;
    assign w_start      = i_char.valid && w_idle;

    bttr_font_rom u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_start),
        .i_code  (i_char.char_code),
        .o_rsp   (w_rsp)
    );

    bttr_cell_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_restart (i_char.restart),
        .i_cfg     (r_cfg),
        .i_rsp     (w_rsp),
        .o_idle    (w_idle),
        .o_pix     (o_pix)
    );

endmodule

FILE: dv/bitmap_text_glyph_renderer_unit_tb.sv
// Self-checking testbench of the glyph renderer: directed and random characters, cell scoreboard.
module bitmap_text_glyph_renderer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bttr_pkg::*;

    // Run length and timing knobs.
    localparam int CycleLimit   = 1_000_000;
    localparam int SettleCycles = 32;     // longer than the accept-plus-fetch pipeline
    localparam int HoldCycles   = 400;    // long receiver stall that backs up the input
    localparam int PhaseItems   = 140;

    // Index that no register answers to; writes to it must leave everything alone.
    localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;

    typedef struct packed {
        logic [CoordBits-1:0] x;
        logic [CoordBits-1:0] y;
        logic                 on;
        logic [ColorBits-1:0] color;
        logic [2:0]           width;
        logic                 last;
    } t_cell;

    // Glyph predictor plus the queue of cells still owed by the block.
    class glyph_scoreboard;
        logic [CoordBits-1:0] start_x;
        logic [CoordBits-1:0] row_top;
        logic [ColorBits-1:0] ink;
        logic [CoordBits-1:0] cursor_x;
        t_cell                cells_due[$];
        int                   errors;

        function new();
            start_x  = StartXRst;
            row_top  = RowTopRst;
            ink      = InkRst;
            cursor_x = StartXRst;
            errors   = 0;
        endfunction

        function logic [CoordBits-1:0] sat_coord(int unsigned v);
            return (v > CoordMax) ? CoordMax : v[CoordBits-1:0];
        endfunction

        function void write_reg(logic [CfgIdxBits-1:0] idx, logic [ColorBits-1:0] data);
            case (idx)
                CFG_START_X:   start_x = data[CoordBits-1:0];
                CFG_ROW_TOP:   row_top = data[CoordBits-1:0];
                CFG_INK_COLOR: ink     = data;
                default: ;
            endcase
        endfunction

        function void note_char(logic [CodeBits-1:0] code, logic restart);
            logic [31:0] entry;
            int unsigned width;
            t_cell       c;
            if (restart)
                cursor_x = start_x;
            entry = (code < FontEntries) ? FontRom[code[RomIdxBits-1:0]] : '0;
            width = 32'(entry[31:WidthShift]);
            if (width > MaxCols)
                width = MaxCols;
            for (int col = 0; col < width; col++) begin
                for (int row = 0; row < GlyphRows; row++) begin
                    c.x     = sat_coord(cursor_x + col);
                    c.y     = sat_coord(row_top + row);
                    c.on    = entry[col * GlyphRows + row];
                    c.color = c.on ? ink : '0;
                    c.width = width[2:0];
                    c.last  = (col == width - 1) && (row == GlyphRows - 1);
                    cells_due.push_back(c);
                end
            end
            cursor_x = sat_coord(cursor_x + width + 1);
        endfunction

        function int field_diff(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_cell(t_cell got);
            t_cell want;
            if (cells_due.size() == 0) begin
                errors++;
                $display("%0t: cell with nothing expected: x=%0h y=%0h", $time, got.x, got.y);
                return;
            end
            want = cells_due.pop_front();
            errors += field_diff("pixel_x", want.x, got.x);
            errors += field_diff("pixel_y", want.y, got.y);
            errors += field_diff("pixel_on", want.on, got.on);
            errors += field_diff("pixel_color", want.color, got.color);
            errors += field_diff("glyph_width", want.width, got.width);
            errors += field_diff("last_cell", want.last, got.last);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    bttr_char_if char_bus ();
    bttr_cfg_if  cfg_bus ();
    bttr_pix_if  pix_bus ();

    bitmap_text_glyph_renderer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus),
        .i_cfg   (cfg_bus),
        .o_pix   (pix_bus)
    );

    glyph_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_asks;
    int hold_served;
    int hold_left;
    int cycle_count = 0;

    // 2 ns clock, starting low.
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog: kill the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever the stimulus
    // asks for one. The hold is counted here so the sender keeps running freely.
    initial begin
        pix_bus.ready = 1'b0;
        hold_served   = 0;
        hold_left     = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                pix_bus.ready <= 1'b0;
                hold_left--;
            end else if (hold_served != hold_asks) begin
                hold_served++;
                hold_left = HoldCycles;
                pix_bus.ready <= 1'b0;
            end else begin
                pix_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Monitor: every handshake is sampled at the edge, before the drivers' updates land.
    always @(posedge i_clk) begin
        t_cell got;
        if (i_rst_n) begin
            if (cfg_bus.valid && cfg_bus.ready)
                sb.write_reg(cfg_bus.index, cfg_bus.data);
            if (char_bus.valid && char_bus.ready)
                sb.note_char(char_bus.char_code, char_bus.restart);
            if (pix_bus.valid && pix_bus.ready) begin
                got.x     = pix_bus.pixel_x;
                got.y     = pix_bus.pixel_y;
                got.on    = pix_bus.pixel_on;
                got.color = pix_bus.pixel_color;
                got.width = pix_bus.glyph_width;
                got.last  = pix_bus.last_cell;
                sb.check_cell(got);
            end
        end
    end

    // Offer one character beat and hold it until accepted. Valid stays high
    // afterwards so back-to-back beats need no bubble; drop it in drain_block.
    task automatic send_char(input logic [CodeBits-1:0] code, input logic restart);
        while ($urandom_range(99) < tx_idle_pct) begin
            char_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= code;
        char_bus.restart   <= restart;
        @(posedge i_clk);
        while (!char_bus.ready)
            @(posedge i_clk);
    endtask

    // Random text: mostly printable characters, with control codes, DEL and
    // high codes mixed in, and a restart now and then to begin a new string.
    task automatic send_random_chars(input int count);
        int                  pick;
        logic [CodeBits-1:0] code;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 80)
                code = CodeBits'($urandom_range(32, 126));
            else if (pick < 85)
                code = CodeBits'($urandom_range(0, 31));
            else if (pick < 88)
                code = 8'd127;
            else
                code = CodeBits'($urandom_range(128, 255));
            send_char(code, $urandom_range(99) < 12);
        end
    endtask

    // Register beat; like send_char, valid is left high for the next write.
    task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [ColorBits-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [ColorBits-1:0] sx, input logic [ColorBits-1:0] rt,
                                input logic [ColorBits-1:0] ink);
        cfg_write(CFG_START_X, sx);
        cfg_write(CFG_ROW_TOP, rt);
        cfg_write(CFG_INK_COLOR, ink);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stop offering, wait for every owed cell, then wait SettleCycles more clocks
    // so the pipeline clears before anything touches the registers.
    task automatic drain_block();
        char_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.cells_due.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = '0;
        char_bus.restart   = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        tx_idle_pct        = 7;
        rx_idle_pct        = 76;
        hold_asks          = 0;
        sb                 = new();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset configuration: cursor starts at its reset column.
        send_char(8'd65, 1'b0);    // 'A'
        send_char(8'd0, 1'b0);     // control code, blank
        send_char(8'd32, 1'b0);    // space: one column, all cells off
        send_char(8'd35, 1'b0);    // '#', widest glyph
        send_char(8'd127, 1'b0);   // DEL, blank
        send_char(8'd128, 1'b0);   // first high code, blank
        send_char(8'd255, 1'b0);   // last high code, blank
        send_char(8'd33, 1'b1);    // '!' with restart
        send_char(8'd77, 1'b0);    // 'M'
        send_char(8'd64, 1'b0);    // '@'
        send_char(8'd126, 1'b0);   // '~'
        send_char(8'd73, 1'b0);    // 'I': single column, all cells on
        drain_block();

        // Top corner: start_x and row_top pinned near the max, upper data bits
        // set to prove masking; the stray index must change nothing.
        cfg_write(CfgUnused, 24'hFFFFFF);
        cfg_write(CFG_START_X, 24'hFFFFFE);
        cfg_write(CFG_ROW_TOP, 24'hABCFFD);
        cfg_write(CFG_INK_COLOR, 24'h000000);
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
        send_char(8'd65, 1'b1);    // x runs into the coordinate ceiling
        send_char(8'd35, 1'b0);    // cursor now saturated
        send_char(8'd200, 1'b0);   // blank at the ceiling
        send_char(8'd46, 1'b0);    // '.'
        drain_block();

        // Origin: zero start and top line, mixed ink.
        apply_config(24'h000000, 24'h000000, 24'hA5C35A);
        send_char(8'd35, 1'b1);
        send_char(8'd81, 1'b0);    // 'Q'
        send_char(8'd40, 1'b0);    // '('
        send_char(8'd1, 1'b0);
        send_char(8'd127, 1'b1);   // restart on a blank glyph
        send_char(8'd65, 1'b0);
        drain_block();

        // Random phase A: slow receiver.
        apply_config(ColorBits'($urandom_range(24'hFFFFFF)),
                     ColorBits'($urandom_range(24'hFFFFFF)),
                     ColorBits'($urandom_range(24'hFFFFFF)));
        send_random_chars(PhaseItems);
        drain_block();

        // Random phase B: slow sender, strings near the right edge, bottom line.
        tx_idle_pct = 76;
        rx_idle_pct = 7;
        cfg_write(CfgUnused, ColorBits'($urandom_range(24'hFFFFFF)));
        apply_config(24'd3950, 24'd4095, 24'hFFFFFF);
        send_random_chars(PhaseItems);
        drain_block();

        // Random phase C: full rate, with one long receiver stall up front so
        // the block fills and pushes back on the sender.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_config(24'd2, ColorBits'($urandom_range(24'd4000)), 24'h000000);
        hold_asks <= hold_asks + 1;
        send_random_chars(PhaseItems);
        drain_block();

        if (sb.errors == 0 && sb.cells_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
